// File: hw/rtl/mfwq_pkg.sv
// mfwq_pkg: request and result beat types, status and operation codes for the
// mutex bank with per-lock wait fifos. No dependencies.
`default_nettype none

package mfwq_pkg;

    localparam int PID_W  = 6;
    localparam int LOCK_W = 2;

    typedef enum logic {
        OP_WAIT   = 1'b0,
        OP_SIGNAL = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_BLOCKED = 3'd1,
        ST_FREED   = 3'd2,
        ST_HANDED  = 3'd3,
        ST_IGNORED = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    typedef struct packed {
        t_op               operation;
        logic [LOCK_W-1:0] lock_id;
        logic [PID_W-1:0]  process_id;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [PID_W-1:0] woken_id;
    } t_res;

endpackage

`default_nettype wire

// File: hw/rtl/mfwq_ram.sv
// mfwq_ram: generic single write port, single read port ram with registered
// read data. No dependencies.
`default_nettype none

module mfwq_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/mfwq_core.sv
// mfwq_core: per-lock held/owner/fifo pointer registers, the shared wait-id
// ram and the decision logic for one request. Depends on mfwq_pkg, mfwq_ram.
`default_nettype none

module mfwq_core #(
    parameter int NUM_LOCKS   = 3,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_acc,
    input  wire logic [mfwq_pkg::LOCK_W-1:0]    i_acc_lock,
    input  wire logic                           i_vld,
    input  wire mfwq_pkg::t_req                 i_req,
    output mfwq_pkg::t_res                      o_res
);

    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH = NUM_LOCKS * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = mfwq_pkg::PID_W;

    logic          r_held  [NUM_LOCKS];
    logic [PW-1:0] r_owner [NUM_LOCKS];
    logic [QW-1:0] r_head  [NUM_LOCKS];
    logic [QW-1:0] r_tail  [NUM_LOCKS];
    logic [CW-1:0] r_count [NUM_LOCKS];
    logic          n_held  [NUM_LOCKS];
    logic [PW-1:0] n_owner [NUM_LOCKS];
    logic [QW-1:0] n_head  [NUM_LOCKS];
    logic [QW-1:0] n_tail  [NUM_LOCKS];
    logic [CW-1:0] n_count [NUM_LOCKS];

    logic          r_byp;
    logic [PW-1:0] r_byp_data;

    logic          in_range;
    logic          sel_held;
    logic [PW-1:0] sel_owner;
    logic [QW-1:0] sel_tail;
    logic [CW-1:0] sel_count;
    logic [AW-1:0] sel_base;
    logic [QW-1:0] acc_head;
    logic [AW-1:0] acc_base;
    logic [AW-1:0] rd_addr;
    logic [PW-1:0] ram_q;
    logic [PW-1:0] head_pid;
    logic          do_grant;
    logic          do_enq;
    logic          do_deq;
    logic          do_free;
    logic          we;
    logic [AW-1:0] waddr;
    mfwq_pkg::t_status status;

    function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] slot);
        logic [QW-1:0] res;
        if (slot == QW'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = slot + QW'(1);
        end
        return res;
    endfunction

    // pick the named lock's registers
    always_comb begin
        in_range  = int'(i_req.lock_id) < NUM_LOCKS;
        sel_held  = 1'b0;
        sel_owner = '0;
        sel_tail  = '0;
        sel_count = '0;
        sel_base  = '0;
        for (int l = 0; l < NUM_LOCKS; l++) begin
            if (int'(i_req.lock_id) == l) begin
                sel_held  = r_held[l];
                sel_owner = r_owner[l];
                sel_tail  = r_tail[l];
                sel_count = r_count[l];
                sel_base  = AW'(l * QUEUE_DEPTH);
            end
        end
    end

    // the ram read was issued in the previous cycle; a write to that slot in that cycle wins
    assign head_pid = r_byp ? r_byp_data : ram_q;

    always_comb begin
        do_grant = 1'b0;
        do_enq   = 1'b0;
        do_deq   = 1'b0;
        do_free  = 1'b0;
        status   = mfwq_pkg::ST_IGNORED;
        if (in_range) begin
            unique case (i_req.operation)
                mfwq_pkg::OP_WAIT: begin
                    if (!sel_held || sel_owner == i_req.process_id) begin
                        do_grant = 1'b1;
                        status   = mfwq_pkg::ST_GRANTED;
                    end else if (sel_count < CW'(QUEUE_DEPTH)) begin
                        do_enq = 1'b1;
                        status = mfwq_pkg::ST_BLOCKED;
                    end else begin
                        status = mfwq_pkg::ST_FULL;
                    end
                end
                mfwq_pkg::OP_SIGNAL: begin
                    if (sel_held && sel_owner == i_req.process_id) begin
                        if (sel_count != '0) begin
                            do_deq = 1'b1;
                            status = mfwq_pkg::ST_HANDED;
                        end else begin
                            do_free = 1'b1;
                            status  = mfwq_pkg::ST_FREED;
                        end
                    end
                end
                default: status = mfwq_pkg::ST_IGNORED;
            endcase
        end
    end

    assign o_res.status   = status;
    assign o_res.woken_id = do_deq ? head_pid : '0;

    assign we    = i_vld && do_enq;
    assign waddr = sel_base + AW'(sel_tail);

    always_comb begin
        for (int l = 0; l < NUM_LOCKS; l++) begin
            n_held[l]  = r_held[l];
            n_owner[l] = r_owner[l];
            n_head[l]  = r_head[l];
            n_tail[l]  = r_tail[l];
            n_count[l] = r_count[l];
            if (i_vld && int'(i_req.lock_id) == l) begin
                if (do_grant) begin
                    n_held[l]  = 1'b1;
                    n_owner[l] = i_req.process_id;
                end
                if (do_enq) begin
                    n_tail[l]  = next_slot(r_tail[l]);
                    n_count[l] = r_count[l] + CW'(1);
                end
                if (do_deq) begin
                    n_head[l]  = next_slot(r_head[l]);
                    n_count[l] = r_count[l] - CW'(1);
                    n_owner[l] = head_pid;
                end
                if (do_free) begin
                    n_held[l]  = 1'b0;
                    n_owner[l] = '0;
                end
            end
        end
    end

    // read address for the request entering now, seeing this cycle's head update
    always_comb begin
        acc_head = '0;
        acc_base = '0;
        for (int l = 0; l < NUM_LOCKS; l++) begin
            if (int'(i_acc_lock) == l) begin
                acc_head = n_head[l];
                acc_base = AW'(l * QUEUE_DEPTH);
            end
        end
        rd_addr = acc_base + AW'(acc_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LOCKS; l++) begin
                r_held[l]  <= 1'b0;
                r_owner[l] <= '0;
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
            r_byp <= 1'b0;
        end else begin
            for (int l = 0; l < NUM_LOCKS; l++) begin
                r_held[l]  <= n_held[l];
                r_owner[l] <= n_owner[l];
                r_head[l]  <= n_head[l];
                r_tail[l]  <= n_tail[l];
                r_count[l] <= n_count[l];
            end
            r_byp <= i_acc && we && waddr == rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_req.process_id;
    end

    mfwq_ram #(
        .WIDTH(PW),
        .DEPTH(DEPTH)
    ) u_wait_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(i_req.process_id),
        .i_re   (i_acc),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

`ifndef SYNTHESIS
    for (genvar g = 0; g < NUM_LOCKS; g++) begin : g_chk
        a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_head[g] == r_tail[g]) ==
            (r_count[g] == '0 || r_count[g] == CW'(QUEUE_DEPTH)))
            else $error("fifo pointers disagree with count");
        a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            !r_held[g] |-> (r_owner[g] == '0 && r_count[g] == '0))
            else $error("free lock with owner or waiters");
    end
    a_byp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> $past(we) && $past(i_acc))
        else $error("bypass without a write");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/mutex_fifo_wait_queue.sv
// mutex_fifo_wait_queue: top level, request register, result register.
// Depends on mfwq_pkg and mfwq_core.
`default_nettype none

// A bank of NUM_LOCKS mutexes, each with a fifo of up to QUEUE_DEPTH waiting
// process ids.
// Request channel: drive i_req with start high; the beat is taken at a rising
// edge where start is high and busy is low. busy stays low, so one request
// can be taken every cycle.
// Result channel: exactly one result beat per request on o_res, marked by
// o_done for a single cycle, in request order. The receiver cannot stall
// this channel: a result must be captured in the cycle o_done is high.
// Throughput is one request per cycle. A request first reads the head slot
// of the named lock's fifo from the wait ram, then takes the decision and
// the state update; the result is registered before o_done rises.
// Reset (i_rst_n low, synchronous) frees all locks and empties every fifo;
// no results are pending afterwards. The wait ram needs no clearing.
module mutex_fifo_wait_queue #(
    parameter int NUM_LOCKS   = 3,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire mfwq_pkg::t_req  i_req,
    output logic                 o_done,
    output mfwq_pkg::t_res       o_res
);

    logic           acc;
    logic           r_vld;
    mfwq_pkg::t_req r_req;
    logic           r_done;
    mfwq_pkg::t_res r_res;
    mfwq_pkg::t_res core_res;

    assign busy = 1'b0;
    assign acc  = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= acc;
            r_done <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= i_req;
        r_res <= core_res;
    end

    mfwq_core #(
        .NUM_LOCKS  (NUM_LOCKS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_acc_lock(i_req.lock_id),
        .i_vld     (r_vld),
        .i_req     (r_req),
        .o_res     (core_res)
    );

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// File: bench/mutex_fifo_wait_queue_tb.sv
// mutex_fifo_wait_queue_tb: self-checking bench for the mutex bank with per-lock
// wait fifos; a shadow lock table predicts every result beat in order.
// Depends on mfwq_pkg and mutex_fifo_wait_queue.
`default_nettype none

module mutex_fifo_wait_queue_tb;

    localparam int NUM_LOCKS    = 3;
    localparam int QUEUE_DEPTH  = 16;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int TOTAL_BEATS  = 1350;
    localparam int PHASE_BEATS  = 50;
    localparam int CALM_BEATS   = 200;
    localparam int TAIL_CYCLES  = 10;
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_REPORTS  = 10;
    localparam int PID_W        = mfwq_pkg::PID_W;
    localparam int LOCK_W       = mfwq_pkg::LOCK_W;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    mfwq_pkg::t_req i_req   = '0;
    logic           busy;
    logic           o_done;
    mfwq_pkg::t_res o_res;

    mutex_fifo_wait_queue #(
        .NUM_LOCKS   (NUM_LOCKS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow lock table
    logic             held_flag [NUM_LOCKS];
    logic [PID_W-1:0] owner_pid [NUM_LOCKS];
    logic [PID_W-1:0] wait_ring [NUM_LOCKS][QUEUE_DEPTH];
    int               ring_head [NUM_LOCKS];
    int               ring_tail [NUM_LOCKS];
    int               ring_count[NUM_LOCKS];

    mfwq_pkg::t_req pending_reqs[$];
    mfwq_pkg::t_res expected_res[$];

    int   beats_planned  = 0;
    int   issued_beats   = 0;
    int   accepted_beats = 0;
    int   mismatch_count = 0;
    int   stall_cycles   = 0;
    int   gap_left       = 0;
    int   idle_pct       = 0;
    bit   calm_tail      = 1'b0;
    logic req_taken      = 1'b0;

    function automatic mfwq_pkg::t_res arbitrate(mfwq_pkg::t_req r);
        mfwq_pkg::t_res res;
        int             lk;
        res.status   = mfwq_pkg::ST_IGNORED;
        res.woken_id = '0;
        lk = int'(r.lock_id);
        if (lk < NUM_LOCKS) begin
            if (r.operation == mfwq_pkg::OP_WAIT) begin
                if (!held_flag[lk] || owner_pid[lk] == r.process_id) begin
                    held_flag[lk] = 1'b1;
                    owner_pid[lk] = r.process_id;
                    res.status    = mfwq_pkg::ST_GRANTED;
                end else if (ring_count[lk] < QUEUE_DEPTH) begin
                    wait_ring[lk][ring_tail[lk]] = r.process_id;
                    ring_tail[lk]  = (ring_tail[lk] + 1) % QUEUE_DEPTH;
                    ring_count[lk] = ring_count[lk] + 1;
                    res.status     = mfwq_pkg::ST_BLOCKED;
                end else begin
                    res.status = mfwq_pkg::ST_FULL;
                end
            end else if (held_flag[lk] && owner_pid[lk] == r.process_id) begin
                if (ring_count[lk] > 0) begin
                    owner_pid[lk]  = wait_ring[lk][ring_head[lk]];
                    ring_head[lk]  = (ring_head[lk] + 1) % QUEUE_DEPTH;
                    ring_count[lk] = ring_count[lk] - 1;
                    res.status     = mfwq_pkg::ST_HANDED;
                    res.woken_id   = owner_pid[lk];
                end else begin
                    held_flag[lk] = 1'b0;
                    owner_pid[lk] = '0;
                    res.status    = mfwq_pkg::ST_FREED;
                end
            end
        end
        return res;
    endfunction

    function automatic void flag_error(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function automatic void queue_req(mfwq_pkg::t_op op, logic [LOCK_W-1:0] lk,
                                      logic [PID_W-1:0] pid);
        mfwq_pkg::t_req r;
        r.operation  = op;
        r.lock_id    = lk;
        r.process_id = pid;
        pending_reqs.push_back(r);
        beats_planned++;
    endfunction

    // acquire, a run of waiters (sometimes past full), then release down the chain;
    // leaves the lock free when it started free
    function automatic void queue_handoff_chain(logic [LOCK_W-1:0] lk);
        logic [PID_W-1:0] first_pid;
        logic [PID_W-1:0] waiters[20];
        logic [PID_W-1:0] w;
        int               n_wait;
        first_pid = PID_W'($urandom_range(63));
        n_wait = ($urandom_range(7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
        queue_req(mfwq_pkg::OP_WAIT, lk, first_pid);
        for (int i = 0; i < n_wait; i++) begin
            do w = PID_W'($urandom_range(63)); while (w == first_pid);
            waiters[i] = w;
            queue_req(mfwq_pkg::OP_WAIT, lk, w);
            if ($urandom_range(9) == 0) queue_req(mfwq_pkg::OP_WAIT, lk, first_pid);
        end
        if ($urandom_range(3) == 0) begin
            do w = PID_W'($urandom_range(63)); while (w == first_pid);
            queue_req(mfwq_pkg::OP_SIGNAL, lk, w);
        end
        queue_req(mfwq_pkg::OP_SIGNAL, lk, first_pid);
        for (int i = 0; i < n_wait && i < QUEUE_DEPTH; i++)
            queue_req(mfwq_pkg::OP_SIGNAL, lk, waiters[i]);
    endfunction

    // walk every held lock back to free, owner first then the waiters in order
    function automatic void queue_release_all();
        for (int lk = 0; lk < NUM_LOCKS; lk++) begin
            if (held_flag[lk]) begin
                queue_req(mfwq_pkg::OP_SIGNAL, LOCK_W'(lk), owner_pid[lk]);
                for (int i = 0; i < ring_count[lk]; i++)
                    queue_req(mfwq_pkg::OP_SIGNAL, LOCK_W'(lk),
                              wait_ring[lk][(ring_head[lk] + i) % QUEUE_DEPTH]);
            end
        end
    endfunction

    task automatic wait_until_drained();
        while (pending_reqs.size() != 0 || issued_beats != accepted_beats ||
               expected_res.size() != 0)
            @(negedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin : driver
        mfwq_pkg::t_req nxt;
        bit             go;
        go  = 1'b0;
        nxt = i_req;
        if (i_rst_n && !(start && !req_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() != 0) begin
                if (!calm_tail && $urandom_range(99) < idle_pct) begin
                    gap_left = $urandom_range(1, 5) - 1;
                end else begin
                    nxt = pending_reqs.pop_front();
                    go  = 1'b1;
                    issued_beats++;
                end
            end
            start <= go;
            i_req <= nxt;
        end
    end

    // accept tracking, prediction and result checking
    always @(posedge i_clk) begin : monitor
        mfwq_pkg::t_res want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            for (int lk = 0; lk < NUM_LOCKS; lk++) begin
                held_flag[lk]  = 1'b0;
                owner_pid[lk]  = '0;
                ring_head[lk]  = 0;
                ring_tail[lk]  = 0;
                ring_count[lk] = 0;
            end
        end else begin
            req_taken <= start && !busy;
            if (o_done) begin
                if (expected_res.size() == 0) begin
                    flag_error($sformatf("unexpected result beat: status %0d woken %0d",
                                         o_res.status, o_res.woken_id));
                end else begin
                    want = expected_res.pop_front();
                    if (o_res.status !== want.status || o_res.woken_id !== want.woken_id)
                        flag_error($sformatf(
                            {"result mismatch: expected status %0d woken %0d, ",
                             "got status %0d woken %0d"},
                            want.status, want.woken_id, o_res.status, o_res.woken_id));
                end
            end
            if (start && !busy) begin
                expected_res.push_back(arbitrate(i_req));
                accepted_beats++;
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int phase_end;
        int pick;

        // directed: range edge, ignored signals, repeat grant, duplicates, handover
        queue_req(mfwq_pkg::OP_WAIT,   2'd3, 6'd63);
        queue_req(mfwq_pkg::OP_SIGNAL, 2'd3, 6'd0);
        queue_req(mfwq_pkg::OP_SIGNAL, 2'd0, 6'd0);
        queue_req(mfwq_pkg::OP_WAIT,   2'd0, 6'd0);
        queue_req(mfwq_pkg::OP_WAIT,   2'd0, 6'd0);
        queue_req(mfwq_pkg::OP_WAIT,   2'd0, 6'd63);
        queue_req(mfwq_pkg::OP_WAIT,   2'd0, 6'd63);
        queue_req(mfwq_pkg::OP_WAIT,   2'd0, 6'd21);
        queue_req(mfwq_pkg::OP_SIGNAL, 2'd0, 6'd42);
        queue_req(mfwq_pkg::OP_SIGNAL, 2'd0, 6'd0);
        queue_req(mfwq_pkg::OP_SIGNAL, 2'd0, 6'd63);
        queue_req(mfwq_pkg::OP_SIGNAL, 2'd0, 6'd63);
        queue_req(mfwq_pkg::OP_SIGNAL, 2'd0, 6'd21);
        queue_req(mfwq_pkg::OP_WAIT,   2'd2, 6'd42);
        queue_req(mfwq_pkg::OP_WAIT,   2'd1, 6'd63);
        queue_req(mfwq_pkg::OP_WAIT,   2'd1, 6'd0);
        queue_req(mfwq_pkg::OP_SIGNAL, 2'd1, 6'd63);
        queue_req(mfwq_pkg::OP_SIGNAL, 2'd1, 6'd0);
        queue_req(mfwq_pkg::OP_SIGNAL, 2'd2, 6'd42);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_planned < TOTAL_BEATS) begin
            // sender holds off until every result of the last phase is in
            wait_until_drained();
            pick = $urandom_range(2);
            idle_pct  = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
            calm_tail = (beats_planned > TOTAL_BEATS - CALM_BEATS);
            queue_release_all();
            phase_end = beats_planned + PHASE_BEATS;
            while (beats_planned < phase_end) begin
                if ($urandom_range(4) == 0)
                    queue_req(mfwq_pkg::t_op'($urandom_range(1)),
                              LOCK_W'($urandom_range(3)), PID_W'($urandom_range(63)));
                else
                    queue_handoff_chain(LOCK_W'($urandom_range(NUM_LOCKS - 1)));
            end
        end

        wait_until_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (expected_res.size() != 0)
            flag_error($sformatf("%0d result beats never arrived", expected_res.size()));
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
